// ===== hw/rtl/scp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants, types and helpers for the segment closest point unit.
// The segment values are fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;
    localparam int MW        = 31;
    localparam int DW        = 33;
    localparam int PW        = 66;
    localparam int LW        = 67;
    localparam int NW        = LW + FRAC_BITS;
    localparam int QW        = 42;
    localparam int SW        = 65;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int PADDR_W    = 5;

    // divider numerator width, quotient stages and pipe depths
    localparam int DN     = PW + CW;
    localparam int DST    = QW + 1;
    localparam int DLAT   = QW + 2;
    localparam int SLAT   = 33;
    localparam int BLAT   = 2 + DLAT + 2 + SLAT;
    localparam int PSPLIT = 33;

    localparam logic [QW-1:0] QCAP = QW'(64'd1 << 40);

    typedef enum logic [2:0] {
        REG_START_X    = 3'd0,
        REG_START_Y    = 3'd1,
        REG_END_X      = 3'd2,
        REG_END_Y      = 3'd3,
        REG_MIN_LENGTH = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic        [MW-1:0] min_length;
    } t_cfg;

    typedef struct packed {
        logic signed [CW-1:0] query_x;
        logic signed [CW-1:0] query_y;
    } t_query;

    typedef struct packed {
        logic signed [CW-1:0] param_t;
        logic        [16:0]   param_t_clamped;
        logic signed [CW-1:0] near_x;
        logic signed [CW-1:0] near_y;
        logic        [CW-1:0] gap;
        logic                 degenerate;
    } t_result;

    // classified item handed from the front part to the back part
    typedef struct packed {
        logic signed [CW-1:0] query_x;
        logic signed [CW-1:0] query_y;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic        [PW-1:0] dot;
        logic                 dneg;
        logic        [DW-2:0] dx_mag;
        logic        [DW-2:0] dy_mag;
        logic                 dx_neg;
        logic                 dy_neg;
        logic        [LW-1:0] lensq;
        logic                 degen;
    } t_work;

    function automatic logic signed [CW-1:0] sat32(input logic signed [QW+1:0] v);
        logic signed [QW+1:0] hi;
        logic signed [QW+1:0] lo;
        hi = (QW+2)'(64'sd2147483647);
        lo = -(QW+2)'(64'sd2147483648);
        if (v > hi) begin
            sat32 = CW'(hi);
        end else if (v < lo) begin
            sat32 = CW'(lo);
        end else begin
            sat32 = CW'(v);
        end
    endfunction

endpackage

// ===== hw/rtl/scp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface scp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/scp_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_divider
// Pipelined restoring divider, one quotient bit per stage, with a flush-free
// enable. Produces quotient and a nonzero remainder flag.
// ----------------------------------------------------------------------------
module scp_divider (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [scp_pkg::DN-1:0]  i_num,
    input  logic [scp_pkg::LW-1:0]  i_den,
    output logic [scp_pkg::QW-1:0]  o_quo,
    output logic                    o_rem_nz
);
    import scp_pkg::*;

    // quotient bits above QW-1 only matter as an overflow flag
    logic [LW:0]   r_rem [DST+1];
    logic [DN-1:0] r_num [DST+1];
    logic [LW-1:0] r_den [DST+1];
    logic [QW:0]   r_quo [DST+1];
    logic          r_ovf [DST+1];

    logic [LW:0] hi_rem;
    logic        hi_ovf;

    // bits above position QW: overflow if numerator >> (QW+1) >= den,
    // otherwise those bits are already the partial remainder
    always_comb begin
        hi_ovf = ((i_num >> DST) >= DN'(i_den));
        hi_rem = (LW+1)'(i_num >> DST);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= hi_rem;
            r_num[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= hi_ovf | (i_den == '0);
        end
    end

    for (genvar g = 0; g < DST; g++) begin : g_stage
        logic [LW:0] trial;
        assign trial = {r_rem[g][LW-1:0], r_num[g][DST-1-g]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[g+1] <= r_num[g];
                r_den[g+1] <= r_den[g];
                r_ovf[g+1] <= r_ovf[g];
                if (trial >= {1'b0, r_den[g]}) begin
                    r_rem[g+1] <= trial - {1'b0, r_den[g]};
                    r_quo[g+1] <= {r_quo[g][QW-1:0], 1'b1};
                end else begin
                    r_rem[g+1] <= trial;
                    r_quo[g+1] <= {r_quo[g][QW-1:0], 1'b0};
                end
            end
        end
    end

    assign o_quo    = (r_ovf[DST] || r_quo[DST][QW]) ? '1 : r_quo[DST][QW-1:0];
    assign o_rem_nz = (r_rem[DST] != '0);
endmodule

// ===== hw/rtl/scp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_front
// Two-stage front end: differences and products, then dot product, squared
// length and the degenerate test. Pushes classified beats into the queue.
// ----------------------------------------------------------------------------
module scp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  scp_pkg::t_cfg  i_cfg,
    scp_stream_if.sink     s_in,
    output logic           o_push,
    output scp_pkg::t_work o_work,
    input  logic           i_space
);
    import scp_pkg::*;

    logic r_v1, n_v1, r_v2, n_v2;
    logic adv;

    logic [PW-1:0] r_p1, r_p2, r_ddx, r_ddy, r_ml2;
    logic          r_n1, r_n2;
    logic [DW-2:0] r_dxm, r_dym;
    logic          r_dxn, r_dyn;
    t_query        r_q;
    logic signed [CW-1:0] r_sx, r_sy;
    t_work         r_w;

    logic signed [DW-1:0] dx, dy, ux, uy;
    logic [DW-2:0] dxm, dym, uxm, uym;
    logic [PW-1:0] dot;
    logic          dneg;
    logic [LW-1:0] lensq;

    // stall only when stage 2 holds a beat the queue cannot take
    assign adv     = !r_v2 || i_space;
    assign s_in.ready = adv;
    assign o_push  = r_v2 && i_space;
    assign o_work  = r_w;

    always_comb begin
        dx  = DW'(i_cfg.end_x) - DW'(i_cfg.start_x);
        dy  = DW'(i_cfg.end_y) - DW'(i_cfg.start_y);
        ux  = DW'(s_in.data.query_x) - DW'(i_cfg.start_x);
        uy  = DW'(s_in.data.query_y) - DW'(i_cfg.start_y);
        dxm = dx[DW-1] ? (DW-1)'(-dx) : dx[DW-2:0];
        dym = dy[DW-1] ? (DW-1)'(-dy) : dy[DW-2:0];
        uxm = ux[DW-1] ? (DW-1)'(-ux) : ux[DW-2:0];
        uym = uy[DW-1] ? (DW-1)'(-uy) : uy[DW-2:0];
    end

    always_comb begin
        n_v1 = r_v1;
        n_v2 = r_v2;
        if (adv) begin
            n_v1 = s_in.valid;
            n_v2 = r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    // stage 1: four 32x32 products and the squared minimum length
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1  <= PW'(dxm) * PW'(uxm);
            r_p2  <= PW'(dym) * PW'(uym);
            r_ddx <= PW'(dxm) * PW'(dxm);
            r_ddy <= PW'(dym) * PW'(dym);
            r_ml2 <= PW'(i_cfg.min_length) * PW'(i_cfg.min_length);
            r_n1  <= dx[DW-1] != ux[DW-1];
            r_n2  <= dy[DW-1] != uy[DW-1];
            r_dxm <= dxm;
            r_dym <= dym;
            r_dxn <= dx[DW-1];
            r_dyn <= dy[DW-1];
            r_q   <= s_in.data;
            r_sx  <= i_cfg.start_x;
            r_sy  <= i_cfg.start_y;
        end
    end

    always_comb begin
        lensq = LW'(r_ddx) + LW'(r_ddy);
        if (r_n1 == r_n2) begin
            dot  = r_p1 + r_p2;
            dneg = r_n1;
        end else if (r_p1 >= r_p2) begin
            dot  = r_p1 - r_p2;
            dneg = r_n1;
        end else begin
            dot  = r_p2 - r_p1;
            dneg = r_n2;
        end
        if (dot == '0) begin
            dneg = 1'b0;
        end
    end

    // stage 2: combine and classify
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w.query_x <= r_q.query_x;
            r_w.query_y <= r_q.query_y;
            r_w.start_x <= r_sx;
            r_w.start_y <= r_sy;
            r_w.dot     <= dot;
            r_w.dneg    <= dneg;
            r_w.dx_mag  <= r_dxm;
            r_w.dy_mag  <= r_dym;
            r_w.dx_neg  <= r_dxn;
            r_w.dy_neg  <= r_dyn;
            r_w.lensq   <= lensq;
            r_w.degen   <= lensq <= LW'(r_ml2);
        end
    end
endmodule

// ===== hw/rtl/scp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_queue
// Small register queue between front and back parts.
// ----------------------------------------------------------------------------
module scp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scp_pkg::t_work i_work,
    output logic           o_space,
    output logic           o_avail,
    input  logic           i_pop,
    output scp_pkg::t_work o_work
);
    import scp_pkg::*;

    t_work            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt, n_cnt;

    assign o_space = r_cnt != (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_avail = r_cnt != '0;
    assign o_work  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_work;
        end
    end
endmodule

// ===== hw/rtl/scp_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module scp_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    input  logic        i_ovf,
    output logic [31:0] o_root
);
    logic [65:0]   r_rem [33];
    logic [63:0]   r_val [33];
    logic [31:0]   r_root [33];
    logic          r_ovf [33];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_val[0]  <= i_val;
            r_root[0] <= '0;
            r_ovf[0]  <= i_ovf;
        end
    end

    for (genvar g = 0; g < 32; g++) begin : g_stage
        logic [65:0] cur;
        logic [65:0] trial;
        assign cur   = {r_rem[g][63:0], r_val[g][63-2*g -: 2]};
        assign trial = {32'd0, r_root[g], 2'b01};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[g+1] <= r_val[g];
                r_ovf[g+1] <= r_ovf[g];
                if (cur >= trial) begin
                    r_rem[g+1]  <= cur - trial;
                    r_root[g+1] <= {r_root[g][30:0], 1'b1};
                end else begin
                    r_rem[g+1]  <= cur;
                    r_root[g+1] <= {r_root[g][30:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_ovf[32] ? '1 : r_root[32];
endmodule

// ===== hw/rtl/scp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_back
// Back end: numerator products, three pipelined dividers, saturation, the
// error products and a pipelined square root, then an output register.
// The whole pipe advances together and stalls when the output is held.
// ----------------------------------------------------------------------------
module scp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    input  scp_pkg::t_work i_work,
    output logic           o_pop,
    scp_stream_if.source   m_out
);
    import scp_pkg::*;

    logic en;
    logic [BLAT-1:0] r_vld;

    typedef struct packed {
        logic signed [CW-1:0] query_x;
        logic signed [CW-1:0] query_y;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic                 dneg;
        logic                 nxneg;
        logic                 nyneg;
        logic                 degen;
    } t_tag;

    typedef struct packed {
        logic signed [CW-1:0] param_t;
        logic        [16:0]   param_t_clamped;
        logic signed [CW-1:0] near_x;
        logic signed [CW-1:0] near_y;
        logic                 degenerate;
    } t_mid;

    // output register is free or being drained
    assign en    = !m_out.valid || m_out.ready;
    assign o_pop = en && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[BLAT-2:0], i_avail};
        end
    end

    // stage a: dot times |d| products, split to stay near 32 bits wide each
    logic [NW-1:0] r_nt0, r_nt;
    logic [2*CW:0] r_pxl, r_pxh, r_pyl, r_pyh;
    logic [LW-1:0] r_len0, r_len;
    t_tag r_ta0, r_ta;
    logic [DN-1:0] r_nx, r_ny;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nt0 <= NW'(i_work.dot) << FRAC_BITS;
            r_pxl <= (2*CW+1)'(i_work.dot[PSPLIT-1:0]) * (2*CW+1)'(i_work.dx_mag);
            r_pxh <= (2*CW+1)'(i_work.dot[PW-1:PSPLIT]) * (2*CW+1)'(i_work.dx_mag);
            r_pyl <= (2*CW+1)'(i_work.dot[PSPLIT-1:0]) * (2*CW+1)'(i_work.dy_mag);
            r_pyh <= (2*CW+1)'(i_work.dot[PW-1:PSPLIT]) * (2*CW+1)'(i_work.dy_mag);
            r_len0 <= i_work.lensq;
            r_ta0.query_x <= i_work.query_x;
            r_ta0.query_y <= i_work.query_y;
            r_ta0.start_x <= i_work.start_x;
            r_ta0.start_y <= i_work.start_y;
            r_ta0.dneg    <= i_work.dneg;
            r_ta0.nxneg   <= i_work.dneg != i_work.dx_neg;
            r_ta0.nyneg   <= i_work.dneg != i_work.dy_neg;
            r_ta0.degen   <= i_work.degen;
        end
    end

    // stage a2: recombine the partial products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nt  <= r_nt0;
            r_nx  <= (DN'(r_pxh) << PSPLIT) + DN'(r_pxl);
            r_ny  <= (DN'(r_pyh) << PSPLIT) + DN'(r_pyl);
            r_len <= r_len0;
            r_ta  <= r_ta0;
        end
    end

    logic [QW-1:0] qt, qx, qy;
    logic rt, rx, ry;
    t_tag r_tg [DLAT];
    t_tag tb;

    scp_divider u_div_t (
        .i_clk(i_clk), .i_en(en), .i_num(DN'(r_nt)), .i_den(r_len),
        .o_quo(qt), .o_rem_nz(rt)
    );
    scp_divider u_div_x (
        .i_clk(i_clk), .i_en(en), .i_num(r_nx), .i_den(r_len),
        .o_quo(qx), .o_rem_nz(rx)
    );
    scp_divider u_div_y (
        .i_clk(i_clk), .i_en(en), .i_num(r_ny), .i_den(r_len),
        .o_quo(qy), .o_rem_nz(ry)
    );

    // side data kept in step with the dividers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tg[0] <= r_ta;
            for (int k = 1; k < DLAT; k++) begin
                r_tg[k] <= r_tg[k-1];
            end
        end
    end

    assign tb = r_tg[DLAT-1];

    function automatic logic signed [QW+1:0] fdiv(input logic neg, input logic [QW-1:0] q,
                                                 input logic rnz);
        logic [QW:0] m;
        m = {1'b0, q} + (QW+1)'(neg && rnz);
        if (m > (QW+1)'(QCAP)) begin
            m = (QW+1)'(QCAP);
        end
        fdiv = neg ? -(QW+2)'(m) : (QW+2)'(m);
    endfunction

    // stage b: floor, cap, offset and saturate
    t_mid r_mb;
    t_tag r_tb;
    logic signed [CW-1:0] tv;
    logic signed [QW+1:0] ox, oy;

    always_comb begin
        tv = sat32(fdiv(tb.dneg, qt, rt));
        ox = fdiv(tb.nxneg, qx, rx) + (QW+2)'(tb.start_x);
        oy = fdiv(tb.nyneg, qy, ry) + (QW+2)'(tb.start_y);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tb <= tb;
            if (tb.degen) begin
                r_mb.param_t         <= '0;
                r_mb.param_t_clamped <= '0;
                r_mb.near_x          <= tb.start_x;
                r_mb.near_y          <= tb.start_y;
            end else begin
                r_mb.param_t <= tv;
                if (tv < 0) begin
                    r_mb.param_t_clamped <= '0;
                end else if (tv > (CW'(1) <<< FRAC_BITS)) begin
                    r_mb.param_t_clamped <= 17'(CW'(1) << FRAC_BITS);
                end else begin
                    r_mb.param_t_clamped <= 17'(tv);
                end
                r_mb.near_x <= sat32(ox);
                r_mb.near_y <= sat32(oy);
            end
            r_mb.degenerate <= tb.degen;
        end
    end

    // stage c: squared error
    logic signed [DW-1:0] ex, ey;
    logic [DW-2:0] exm, eym;
    logic [SW-1:0] r_sq;
    t_mid r_mc;

    always_comb begin
        ex  = DW'(r_tb.query_x) - DW'(r_mb.near_x);
        ey  = DW'(r_tb.query_y) - DW'(r_mb.near_y);
        exm = ex[DW-1] ? (DW-1)'(-ex) : ex[DW-2:0];
        eym = ey[DW-1] ? (DW-1)'(-ey) : ey[DW-2:0];
    end

    logic [63:0] r_a, r_b;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a  <= 64'(exm) * 64'(exm);
            r_b  <= 64'(eym) * 64'(eym);
            r_mc <= r_mb;
        end
    end

    assign r_sq = SW'(r_a) + SW'(r_b);

    logic [31:0] root;
    t_mid r_md [SLAT];
    t_mid md;

    scp_isqrt u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_val(r_sq[63:0]), .i_ovf(r_sq[64]),
        .o_root(root)
    );

    // side data kept in step with the square root
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_md[0] <= r_mc;
            for (int k = 1; k < SLAT; k++) begin
                r_md[k] <= r_md[k-1];
            end
        end
    end

    assign md = r_md[SLAT-1];

    t_result r_out;
    logic    r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_vld[BLAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.param_t         <= md.param_t;
            r_out.param_t_clamped <= md.param_t_clamped;
            r_out.near_x          <= md.near_x;
            r_out.near_y          <= md.near_y;
            r_out.gap             <= root;
            r_out.degenerate      <= md.degenerate;
        end
    end

    assign m_out.valid = r_ov;
    assign m_out.data  = r_out;
endmodule

// ===== hw/rtl/segment_closest_point_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_closest_point_unit
// Projects a query point onto the configured segment, giving t, clamped t,
// the projected point and the distance to it.
// ----------------------------------------------------------------------------
// One query beat is taken every cycle while the output is drained. The result
// path runs through two front stages, the queue, two product stages, the
// 44-stage pipelined dividers (one quotient bit per stage), two stages of
// saturation and squaring, the 33-stage square root, and the output register.
// While the output is held the back pipe freezes and the four-beat queue and
// front stages fill first.
// Segment registers sit behind an APB port at byte address 4*i.
module segment_closest_point_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [scp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    scp_stream_if.sink                 s_query,
    scp_stream_if.source               m_result
);
    import scp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     push, space, avail, pop;
    t_work    wf, wq;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_x    <= '0;
            r_cfg.start_y    <= '0;
            r_cfg.end_x      <= '0;
            r_cfg.end_y      <= '0;
            r_cfg.min_length <= MW'(1);
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_START_X:    r_cfg.start_x    <= pwdata;
                REG_START_Y:    r_cfg.start_y    <= pwdata;
                REG_END_X:      r_cfg.end_x      <= pwdata;
                REG_END_Y:      r_cfg.end_y      <= pwdata;
                REG_MIN_LENGTH: r_cfg.min_length <= pwdata[MW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_START_X:    prdata = r_cfg.start_x;
            REG_START_Y:    prdata = r_cfg.start_y;
            REG_END_X:      prdata = r_cfg.end_x;
            REG_END_Y:      prdata = r_cfg.end_y;
            REG_MIN_LENGTH: prdata = {1'b0, r_cfg.min_length};
            default:        prdata = '0;
        endcase
    end

    scp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .s_in(s_query),
        .o_push(push), .o_work(wf), .i_space(space)
    );

    scp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_work(wf),
        .o_space(space), .o_avail(avail), .i_pop(pop), .o_work(wq)
    );

    scp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(avail), .i_work(wq),
        .o_pop(pop), .m_out(m_result)
    );
endmodule

// ===== hw/rtl/scp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module scp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [16:0] o_tc,
    input logic [31:0] o_t,
    input logic        o_degen
);
    // stalled beat stays valid and keeps its t
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_t))
        else $error("result beat changed while stalled");

    // clamped t never above one
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_tc <= 17'h10000)
        else $error("clamped t out of range");

    // degenerate beats carry zero t
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degen |-> o_t == '0 && o_tc == '0)
        else $error("degenerate beat with nonzero t");

    // clamped t follows t where in range
    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_t[31] && o_t <= 32'h10000 |-> o_tc == o_t[16:0])
        else $error("clamped t disagrees with t");
endmodule

bind segment_closest_point_unit scp_checker u_scp_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(m_result.valid),
    .i_ready(m_result.ready),
    .o_tc(m_result.data.param_t_clamped),
    .o_t(m_result.data.param_t),
    .o_degen(m_result.data.degenerate)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment closest point unit: segments are set
// over APB between phases, query beats in the random phases are driven with random gaps,
// and the result stream is compared against a wide-integer projection predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import scp_pkg::*;

    class proj_scoreboard;
        t_result pending_q[$];
        int      mismatches;
        logic signed [31:0] sx, sy, ex, ey;
        logic [30:0] min_len;

        function new();
            mismatches = 0;
            sx = 0; sy = 0; ex = 0; ey = 0; min_len = 31'd1;
        endfunction

        function automatic logic signed [31:0] clip32(logic signed [127:0] v);
            if (v > 128'sd2147483647) return 32'sh7fffffff;
            if (v < -128'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        // floor of n/d with magnitude capped at 2^40
        function automatic logic signed [127:0] floor_quot(logic signed [127:0] n,
                                                          logic signed [127:0] d);
            logic [127:0] mn, q, r;
            logic signed [127:0] res;
            mn = n < 0 ? -n : n;
            q = mn / d;
            r = mn % d;
            if (n < 0 && r != 0) q = q + 1;
            if (q > (128'd1 << 40)) q = 128'd1 << 40;
            res = q;
            return n < 0 ? -res : res;
        endfunction

        function automatic logic [63:0] root_floor(logic [64:0] v);
            logic [64:0] lo, hi, mid;
            lo = 0; hi = 65'd1 << 33;
            while (hi - lo > 1) begin
                mid = (lo + hi) >> 1;
                if (mid * mid <= v) lo = mid; else hi = mid;
            end
            return lo[63:0];
        endfunction

        function void note_query(t_query q);
            logic signed [127:0] dx, dy, ux, uy, lsq, dot, t, nx, ny, qx, qy, exd, eyd;
            logic [64:0] s;
            logic [63:0] g;
            t_result r;
            dx = 128'(ex) - 128'(sx); dy = 128'(ey) - 128'(sy);
            qx = 128'(q.query_x); qy = 128'(q.query_y);
            ux = qx - 128'(sx); uy = qy - 128'(sy);
            lsq = dx * dx + dy * dy;
            r.degenerate = lsq <= 128'(min_len) * 128'(min_len);
            if (r.degenerate) begin
                r.param_t = 0; r.param_t_clamped = 0; nx = sx; ny = sy;
            end else begin
                dot = dx * ux + dy * uy;
                t = clip32(floor_quot(dot <<< FRAC_BITS, lsq));
                r.param_t = t[31:0];
                if (t < 0) r.param_t_clamped = 0;
                else if (t > (128'sd1 <<< FRAC_BITS)) r.param_t_clamped = 17'h10000;
                else r.param_t_clamped = t[16:0];
                nx = clip32(128'(sx) + floor_quot(dot * dx, lsq));
                ny = clip32(128'(sy) + floor_quot(dot * dy, lsq));
            end
            r.near_x = nx[31:0]; r.near_y = ny[31:0];
            exd = qx - nx; eyd = qy - ny;
            s = 65'(exd * exd) + 65'(eyd * eyd);
            if (s[64]) g = 64'hffffffff;
            else g = root_floor(s);
            r.gap = g > 64'hffffffff ? 32'hffffffff : g[31:0];
            pending_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = pending_q.pop_front();
            if (got.param_t !== want.param_t || got.param_t_clamped !== want.param_t_clamped
                || got.near_x !== want.near_x || got.near_y !== want.near_y
                || got.gap !== want.gap || got.degenerate !== want.degenerate) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp %p got %p", want, got);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    scp_stream_if #(.T(t_query))  q_if();
    scp_stream_if #(.T(t_result)) r_if();

    segment_closest_point_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .s_query(q_if.sink), .m_result(r_if.source)
    );

    proj_scoreboard sb = new();
    int  idle_pct = 27;
    bit  hold_off = 0;
    bit  stim_done = 0;
    int  quiet_cycles = 0;
    logic signed [31:0] seg_sx, seg_sy, seg_ex, seg_ey;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        q_if.valid = 0; q_if.data = '0; r_if.ready = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && r_if.valid && r_if.ready) sb.check_result(r_if.data);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) r_if.ready <= 0;
        else r_if.ready <= $urandom_range(99) >= idle_pct;
    end

    always @(posedge i_clk) begin
        if ((q_if.valid && q_if.ready) || (r_if.valid && r_if.ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= PADDR_W'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
        case (idx)
            REG_START_X: sb.sx = val;
            REG_START_Y: sb.sy = val;
            REG_END_X: sb.ex = val;
            REG_END_Y: sb.ey = val;
            REG_MIN_LENGTH: sb.min_len = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_segment(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                               logic [31:0] by, logic [31:0] ml);
        q_if.valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        reg_write(REG_START_X, ax);
        reg_write(REG_START_Y, ay);
        reg_write(REG_END_X, bx);
        reg_write(REG_END_Y, by);
        reg_write(REG_MIN_LENGTH, ml);
        seg_sx = ax; seg_sy = ay; seg_ex = bx; seg_ey = by;
    endtask

    task automatic send_query(logic [31:0] x, logic [31:0] y, bit gaps);
        t_query q;
        q.query_x = x; q.query_y = y;
        if (gaps) begin
            while ($urandom_range(99) < idle_pct) begin
                q_if.valid <= 0;
                @(posedge i_clk);
            end
        end
        q_if.valid <= 1; q_if.data <= q;
        @(posedge i_clk);
        while (!q_if.ready) @(posedge i_clk);
        sb.note_query(q);
    endtask

    function automatic logic [31:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
            default: return $urandom_range(32'h4000_0000) - 32'h2000_0000;
        endcase
    endfunction

    // random query near the segment, mostly around its span
    function automatic logic [31:0] near_seg(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [63:0] m;
        m = (64'(a) + 64'(b)) / 2 + $signed(64'($urandom_range(32'h0004_0000)))
            - 64'sh2_0000;
        m = m + ((64'(b) - 64'(a)) * ($signed(64'($urandom_range(300))) - 150)) / 100;
        if (m > 64'sh7fffffff) m = 64'sh7fffffff;
        if (m < -64'sh80000000) m = -64'sh80000000;
        return m[31:0];
    endfunction

    initial begin
        logic [31:0] qx, qy;
        int n, mode;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        @(posedge i_clk);
        // reset segment: degenerate
        send_query(32'h7fffffff, 32'h80000000, 0);
        send_query(32'h0, 32'h0, 0);
        set_segment(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
        send_query(32'h0000_8000, 32'h0001_0000, 0);
        send_query(32'hffff_0000, 32'h0, 0);
        send_query(32'h0002_0000, 32'h0, 0);
        send_query(32'h7fffffff, 32'h7fffffff, 0);
        send_query(32'h80000000, 32'h80000000, 0);
        send_query(32'h0001_0000, 32'h0, 0);
        set_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_query(32'h0, 32'h0, 0);
        set_segment(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h0);
        send_query(32'h7fffffff, 32'h7fffffff, 0);
        send_query(32'h80000000, 32'h80000000, 0);
        send_query(32'h7fffffff, 32'h80000000, 0);
        set_segment(32'h0, 32'h0, 32'h1, 32'h0, 32'h0);
        send_query(32'h7fffffff, 32'h0, 0);
        send_query(32'h80000000, 32'h7fffffff, 0);
        set_segment(32'h0, 32'h0, 32'h0, 32'h2, 32'h1);
        send_query(32'h5, 32'h7fffffff, 0);
        set_segment(32'h1000, 32'h0, 32'h0, 32'h0, 32'h1000);
        send_query(32'h5, 32'h5, 0);
        // pressure: receiver holds off while queries keep coming
        set_segment(32'hfff0_0000, 32'h0003_0000, 32'h0020_0000, 32'hffe0_0000, 32'h1);
        hold_off = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            for (int k = 0; k < 150; k++)
                send_query(near_seg(seg_sx, seg_ex), near_seg(seg_sy, seg_ey), 0);
        join
        for (int ph = 0; ph < 16; ph++) begin
            mode = ph % 3;
            if (ph == 15)
                set_segment(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
                            rnd_coord(mode), $urandom_range(32'h7fffffff));
            else
                set_segment(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
                            rnd_coord(mode), $urandom_range(ph % 4 == 0 ? 32'h3_0000 : 8));
            idle_pct = (ph == 5) ? 0 : 27;
            n = 90;
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(9) < 7) begin
                    qx = near_seg(seg_sx, seg_ex); qy = near_seg(seg_sy, seg_ey);
                end else begin
                    qx = $urandom; qy = $urandom;
                end
                send_query(qx, qy, 1);
            end
        end
        q_if.valid <= 0;
        idle_pct = 27;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
